FILE: hdl/alsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the adjacent label set counter.
// No dependencies; imported by every module of the block.
package alsc_pkg;

  localparam int unsigned LABEL_W     = 8;
  localparam int unsigned ROW_WIDTH_W = 11;
  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned NUM_LABELS  = 1 << LABEL_W;

  // Line buffer depth, largest supported row
  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CMP_W     = (COL_W + 1 > ROW_WIDTH_W) ? COL_W + 1 : ROW_WIDTH_W;

  // Queue between front and back, power of two
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BACKGROUND = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_WIDTH  = 2'd2;

  localparam logic [LABEL_W-1:0]     TARGET_RST     = 8'd65;
  localparam logic [LABEL_W-1:0]     BACKGROUND_RST = 8'd46;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST  = 11'd1024;

  typedef struct packed {
    logic [LABEL_W-1:0]     target;
    logic [LABEL_W-1:0]     background;
    logic [ROW_WIDTH_W-1:0] row_width;
  } alsc_cfg_t;

  // Classified pixel: up to two labels to add to the seen set
  typedef struct packed {
    logic               last;
    logic               hit0;
    logic [LABEL_W-1:0] lab0;
    logic               hit1;
    logic [LABEL_W-1:0] lab1;
  } alsc_item_t;

endpackage

FILE: hdl/alsc_front.sv
`timescale 1ns / 1ps
// Front end: raster position, line buffer of the row above and pair classification.
// Depends on alsc_pkg.
module alsc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  alsc_pkg::alsc_cfg_t cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          label_i,
  input  logic                last_pixel_i,
  output logic                push_o,
  output alsc_pkg::alsc_item_t item_o,
  input  logic                full_i
);
  import alsc_pkg::*;

  logic [LABEL_W-1:0] line_mem [MAX_WIDTH];

  logic [COL_W-1:0]   col_q, col_d;
  logic [LABEL_W-1:0] left_q, left_d;
  logic               first_q, first_d;
  logic               s1_valid_q, s1_valid_d;

  logic [LABEL_W-1:0] s1_lab_q, s1_left_q, above_q;
  logic               s1_has_left_q, s1_has_above_q, s1_last_q;

  logic               accept;
  logic [CMP_W-1:0]   rw_ext, w_eff, col_next;
  logic               end_row;

  assign in_ready_o = !s1_valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = s1_valid_q && !full_i;

  always_comb begin
    rw_ext = CMP_W'(cfg_i.row_width);
    priority if (rw_ext == '0) begin
      w_eff = CMP_W'(1);
    end else if (rw_ext > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = rw_ext;
    end
    col_next = CMP_W'(col_q) + CMP_W'(1);
    end_row  = col_next >= w_eff;
  end

  always_comb begin
    col_d      = col_q;
    left_d     = left_q;
    first_d    = first_q;
    s1_valid_d = s1_valid_q;
    if (push_o) begin
      s1_valid_d = 1'b0;
    end
    if (accept) begin
      s1_valid_d = 1'b1;
      left_d     = label_i;
      if (end_row) begin
        col_d   = '0;
        first_d = 1'b0;
      end else begin
        col_d = col_next[COL_W-1:0];
      end
      // new frame starts at the top-left corner
      if (last_pixel_i) begin
        col_d   = '0;
        left_d  = '0;
        first_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      left_q     <= '0;
      first_q    <= 1'b1;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      left_q     <= left_d;
      first_q    <= first_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  // Line buffer: read the old entry and overwrite it at the same edge
  always_ff @(posedge clk_i) begin
    if (accept) begin
      above_q         <= line_mem[col_q];
      line_mem[col_q] <= label_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_lab_q       <= label_i;
      s1_left_q      <= left_q;
      s1_has_left_q  <= col_q != '0;
      s1_has_above_q <= !first_q;
      s1_last_q      <= last_pixel_i;
    end
  end

  // Classify: a target pixel collects its neighbors, any other pixel
  // collects itself when a neighbor is the target.
  logic lab_is_t, left_ok, above_ok, lab_ok, near_t;

  always_comb begin
    lab_is_t = s1_lab_q == cfg_i.target;
    left_ok  = s1_left_q != cfg_i.target && s1_left_q != cfg_i.background;
    above_ok = above_q != cfg_i.target && above_q != cfg_i.background;
    lab_ok   = !lab_is_t && s1_lab_q != cfg_i.background;
    near_t   = (s1_has_left_q && s1_left_q == cfg_i.target) ||
               (s1_has_above_q && above_q == cfg_i.target);

    item_o.last = s1_last_q;
    if (lab_is_t) begin
      item_o.hit0 = s1_has_left_q && left_ok;
      item_o.lab0 = s1_left_q;
    end else begin
      item_o.hit0 = near_t && lab_ok;
      item_o.lab0 = s1_lab_q;
    end
    item_o.hit1 = lab_is_t && s1_has_above_q && above_ok;
    item_o.lab1 = above_q;
  end

endmodule

FILE: hdl/alsc_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified pixels between front and back.
// Depends on alsc_pkg.
module alsc_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  alsc_pkg::alsc_item_t item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output alsc_pkg::alsc_item_t item_o,
  output logic                 empty_o
);
  import alsc_pkg::*;

  alsc_item_t            slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]       fill_q, fill_d;

  assign full_o  = fill_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty_o = fill_q == '0;
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   fill_d = fill_q + (QPTR_W+1)'(1);
      2'b01:   fill_d = fill_q - (QPTR_W+1)'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

FILE: hdl/alsc_back.sv
`timescale 1ns / 1ps
// Back end: seen-label set, running count and the result register.
// Depends on alsc_pkg.
module alsc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  alsc_pkg::alsc_item_t item_i,
  input  logic                 empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [8:0]           distinct_count_o
);
  import alsc_pkg::*;

  logic [NUM_LABELS-1:0] seen_q, seen_d;
  logic [COUNT_W-1:0]    count_q, count_d, sum;
  logic [COUNT_W-1:0]    result_q;
  logic                  out_valid_q, out_valid_d;
  logic                  new0, new1;

  // A last item waits while the previous result is still held
  assign pop_o = !empty_i && (!item_i.last || !out_valid_q || out_ready_i);

  always_comb begin
    new0 = item_i.hit0 && !seen_q[item_i.lab0];
    new1 = item_i.hit1 && !seen_q[item_i.lab1] &&
           !(item_i.hit0 && item_i.lab0 == item_i.lab1);
    sum  = count_q + COUNT_W'(new0) + COUNT_W'(new1);

    seen_d      = seen_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop_o) begin
      if (item_i.last) begin
        seen_d      = '0;
        count_d     = '0;
        out_valid_d = 1'b1;
      end else begin
        if (item_i.hit0) seen_d[item_i.lab0] = 1'b1;
        if (item_i.hit1) seen_d[item_i.lab1] = 1'b1;
        count_d = sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.last) begin
      result_q <= sum;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign distinct_count_o = result_q;

endmodule

FILE: hdl/adjacent_label_set_counter.sv
`timescale 1ns / 1ps
// Top level of the adjacent label set counter: configuration registers and wiring.
// Depends on alsc_pkg, alsc_front, alsc_queue and alsc_back.
//
// Usage:
//   Pixels enter on the in channel (label_i, last_pixel_i) in raster order
//   with a valid/ready handshake, one transaction per cycle when the back end
//   keeps up. For each frame the block counts distinct labels that touch the
//   target label through a 4-neighbor edge, skipping background and target.
//   The frame's last pixel produces one result transaction on the out
//   channel (distinct_count_o); other pixels produce none.
//   From accepting the last pixel to out_valid_o the pixel passes the line
//   buffer read stage, then a queue slot, then the back-end update into the
//   result register.
//   Throughput: 1 pixel per cycle when the back end keeps up, set by the
//   single-port line buffer and the one-transaction-per-cycle seen-set update.
//   When the receiver stalls, the result register holds; pixels of the next
//   frame keep flowing until the next last pixel reaches the back end, then
//   the queue fills and in_ready_o drops.
//   Reset clears the seen set, the count and the frame position at once; no
//   clearing pass is needed. Configuration registers (target, background,
//   row width) load through cfg_we_i and return to their defaults at reset.
module adjacent_label_set_counter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [alsc_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [10:0]                     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [7:0]                      label_i,
  input  logic                            last_pixel_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [8:0]                      distinct_count_o
);
  import alsc_pkg::*;

  alsc_cfg_t  cfg_q, cfg_d;
  alsc_item_t front_item, head_item;
  logic       push, full, pop, empty;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_TARGET:     cfg_d.target     = cfg_wdata_i[LABEL_W-1:0];
        REG_BACKGROUND: cfg_d.background = cfg_wdata_i[LABEL_W-1:0];
        REG_ROW_WIDTH:  cfg_d.row_width  = cfg_wdata_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target     <= TARGET_RST;
      cfg_q.background <= BACKGROUND_RST;
      cfg_q.row_width  <= ROW_WIDTH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  alsc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .label_i      (label_i),
    .last_pixel_i (last_pixel_i),
    .push_o       (push),
    .item_o       (front_item),
    .full_i       (full)
  );

  alsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (empty)
  );

  alsc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (head_item),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .distinct_count_o (distinct_count_o)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full && !pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty)
    else $error("queue read while empty");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(pop && head_item.last))
    else $error("result without a last pixel");

  // Target equal to background leaves 255 countable labels
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distinct_count_o <= 9'd255)
    else $error("count exceeds countable labels");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for adjacent_label_set_counter: streams label maps, predicts
// the distinct neighbor count per frame and checks every result transaction.
// Depends on alsc_pkg and the adjacent_label_set_counter RTL.
module testbench;
  import alsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i   = '0;
  logic [10:0]           cfg_wdata_i  = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            label_i      = '0;
  logic                  last_pixel_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [8:0]            distinct_count_o;

  adjacent_label_set_counter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .label_i         (label_i),
    .last_pixel_i    (last_pixel_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .distinct_count_o(distinct_count_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Predicted state of the block
  logic [LABEL_W-1:0]     tgt          = TARGET_RST;
  logic [LABEL_W-1:0]     bkg          = BACKGROUND_RST;
  logic [ROW_WIDTH_W-1:0] width_reg    = ROW_WIDTH_RST;
  logic [7:0]             row_mem [MAX_WIDTH];
  logic [7:0]             prev_lab     = '0;
  int unsigned            col_pos      = 0;
  bit                     in_first_row = 1'b1;
  bit                     touching_seen [NUM_LABELS];
  int unsigned            touching_total = 0;

  logic [8:0]  expected_counts [$];
  int unsigned errors      = 0;
  int unsigned cycles      = 0;
  int          tx_gap_max  = 5;
  int          rx_gap_max  = 5;
  int          rx_wait     = 0;
  logic        rx_block    = 1'b0;
  logic [7:0]  label_pool [4];

  function automatic void note_label(input logic [7:0] lab);
    if (lab == tgt || lab == bkg) return;
    if (!touching_seen[lab]) begin
      touching_seen[lab] = 1'b1;
      touching_total++;
    end
  endfunction

  function automatic void check_touch(input logic [7:0] a, input logic [7:0] b);
    if (a == tgt) note_label(b);
    if (b == tgt) note_label(a);
  endfunction

  // Advance the frame by one pixel; return 1 with the count on the last pixel
  function automatic bit advance_label_map(input logic [7:0] lab, input logic last,
                                           output logic [8:0] cnt);
    int unsigned w;
    int unsigned c;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
    if (c > 0) check_touch(prev_lab, lab);
    if (!in_first_row) check_touch(row_mem[c], lab);
    row_mem[c] = lab;
    prev_lab   = lab;
    if (c + 1 >= w) begin
      col_pos      = 0;
      in_first_row = 1'b0;
    end else begin
      col_pos = c + 1;
    end
    cnt = touching_total[8:0];
    if (!last) return 1'b0;
    foreach (touching_seen[i]) touching_seen[i] = 1'b0;
    touching_total = 0;
    prev_lab       = '0;
    col_pos        = 0;
    in_first_row   = 1'b1;
    return 1'b1;
  endfunction

  function automatic void check_count(input logic [8:0] got);
    logic [8:0] want;
    if (expected_counts.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result transaction: count %0d", got);
    end else begin
      want = expected_counts.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("count error: expected %0d, got %0d", want, got);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: check each result, then stall a random number of cycles
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_ready_i) begin
      check_count(distinct_count_o);
      rx_wait = $urandom_range(0, rx_gap_max);
    end
    if (!rst_ni || rx_block) begin
      out_ready_i <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic hold_receiver(input int n);
    fork
      begin
        rx_block <= 1'b1;
        repeat (n) @(posedge clk_i);
        rx_block <= 1'b0;
      end
    join_none
  endtask

  task automatic send_pixel(input logic [7:0] lab, input logic last);
    int         gap;
    logic [8:0] cnt;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    label_i      <= lab;
    last_pixel_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    if (advance_label_map(lab, last, cnt)) begin
      expected_counts.insert(expected_counts.size(), cnt);
    end
  endtask

  // Drop valid and wait until every result is back and the pipeline is empty
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [10:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_TARGET:     tgt = data[7:0];
      REG_BACKGROUND: bkg = data[7:0];
      REG_ROW_WIDTH:  width_reg = data;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic void refill_pool();
    foreach (label_pool[i]) label_pool[i] = 8'($urandom_range(0, 255));
  endfunction

  // Favor the target and a few labels so that frames have plenty of contacts
  function automatic logic [7:0] pick_label();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return tgt;
    if (r == 4) return bkg;
    if (r < 9) return label_pool[$urandom_range(0, 3)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_frame(input int len);
    for (int i = 0; i < len; i++) send_pixel(pick_label(), i == len - 1);
  endtask

  task automatic test_reset_defaults();
    logic [7:0] pix [12];
    pix = '{TARGET_RST, 8'd66, BACKGROUND_RST, TARGET_RST, TARGET_RST, 8'd70, 8'd255,
            TARGET_RST, 8'd0, 8'd0, 8'd66, TARGET_RST};
    foreach (pix[i]) send_pixel(pix[i], i == 11);
    // single-pixel frame
    send_pixel(TARGET_RST, 1'b1);
  endtask

  task automatic test_row_width_limits();
    wait_idle();
    refill_pool();
    write_reg(REG_ROW_WIDTH, 11'd0);
    send_random_frame(12);
    wait_idle();
    write_reg(REG_ROW_WIDTH, 11'd1);
    send_random_frame(12);
    wait_idle();
    // saturates to the line buffer depth; run one full row plus a few pixels
    write_reg(REG_ROW_WIDTH, 11'h7FF);
    tx_gap_max = 1;
    for (int i = 0; i < MAX_WIDTH + 8; i++) send_pixel(pick_label(), i == MAX_WIDTH + 7);
    tx_gap_max = 5;
  endtask

  task automatic test_label_extremes();
    logic [7:0] pix [12];
    pix = '{8'd255, 8'd0, 8'd128, 8'd127, 8'd0, 8'd1, 8'd254, 8'd0,
            8'd255, 8'd255, 8'd0, 8'd128};
    wait_idle();
    // upper data bits must be ignored for 8-bit registers
    write_reg(REG_TARGET, 11'h700);
    write_reg(REG_BACKGROUND, 11'h0FF);
    write_reg(REG_ROW_WIDTH, 11'd4);
    foreach (pix[i]) send_pixel(pix[i], i == 11);
    wait_idle();
    // target equal to background
    write_reg(REG_BACKGROUND, 11'h000);
    refill_pool();
    send_random_frame(12);
    wait_idle();
    write_reg(REG_SPARE, 11'($urandom_range(0, 2047)));
    send_random_frame(8);
  endtask

  task automatic test_most_neighbors();
    wait_idle();
    write_reg(REG_TARGET, 11'd200);
    write_reg(REG_BACKGROUND, 11'd7);
    write_reg(REG_ROW_WIDTH, 11'd1);
    tx_gap_max = 1;
    for (int l = 0; l < NUM_LABELS; l++) begin
      send_pixel(8'd200, 1'b0);
      send_pixel(8'(l), l == NUM_LABELS - 1);
    end
    tx_gap_max = 5;
  endtask

  task automatic test_midrow_width_change();
    wait_idle();
    refill_pool();
    write_reg(REG_ROW_WIDTH, 11'd8);
    for (int i = 0; i < 5; i++) send_pixel(pick_label(), 1'b0);
    wait_idle();
    // column already past the new end: row closes on the next pixel
    write_reg(REG_ROW_WIDTH, 11'd3);
    send_random_frame(10);
    wait_idle();
    write_reg(REG_ROW_WIDTH, 11'd8);
    for (int i = 0; i < 10; i++) send_pixel(pick_label(), 1'b0);
    wait_idle();
    write_reg(REG_ROW_WIDTH, 11'd6);
    send_random_frame(14);
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_reg(REG_ROW_WIDTH, 11'd2);
    tx_gap_max = 0;
    rx_gap_max = 0;
    refill_pool();
    hold_receiver(300);
    repeat (15) send_random_frame(3);
    // pause the sender until every result has arrived
    wait_idle();
    tx_gap_max = 5;
    rx_gap_max = 5;
  endtask

  task automatic test_random_frames();
    int sent;
    int frames;
    int len;
    sent   = 0;
    frames = 0;
    while (sent < 500 || frames < 40) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        write_reg(REG_TARGET, 11'($urandom_range(0, 2047)));
        if ($urandom_range(0, 5) == 0) write_reg(REG_BACKGROUND, {3'b000, tgt});
        else write_reg(REG_BACKGROUND, 11'($urandom_range(0, 2047)));
        case ($urandom_range(0, 9))
          0:       write_reg(REG_ROW_WIDTH, 11'($urandom_range(0, 2)));
          1:       write_reg(REG_ROW_WIDTH, 11'($urandom_range(MAX_WIDTH + 1, 2047)));
          default: write_reg(REG_ROW_WIDTH, 11'($urandom_range(1, 12)));
        endcase
      end
      tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
      refill_pool();
      len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
      send_random_frame(len);
      sent += len;
      frames++;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_row_width_limits();
    test_label_extremes();
    test_most_neighbors();
    test_midrow_width_change();
    test_backpressure();
    test_random_frames();
    wait_idle();
    errors += expected_counts.size();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
